// ===== rtl/fss_pkg.sv =====
// Shared types, format codes and signature tables for the file signature sniffer.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none
package fss_pkg;

    localparam int SIG_COUNT = 14;
    localparam int POS_W     = 6;
    localparam logic [POS_W-1:0] POS_SAT = POS_W'(37);

    // Format codes as they appear on the result.
    localparam logic [3:0] FMT_NONE = 4'd0;
    localparam logic [3:0] FMT_PNG  = 4'd1;
    localparam logic [3:0] FMT_JPEG = 4'd2;
    localparam logic [3:0] FMT_GIF  = 4'd3;
    localparam logic [3:0] FMT_BMP  = 4'd4;
    localparam logic [3:0] FMT_WEBP = 4'd5;
    localparam logic [3:0] FMT_TIFF = 4'd6;
    localparam logic [3:0] FMT_PDF  = 4'd7;
    localparam logic [3:0] FMT_WAV  = 4'd8;
    localparam logic [3:0] FMT_MP3  = 4'd9;
    localparam logic [3:0] FMT_MP4  = 4'd10;
    localparam logic [3:0] FMT_OGG  = 4'd11;
    localparam logic [3:0] FMT_ZIP  = 4'd12;

    // Marker bytes that steer the logic beyond plain pattern compares.
    localparam logic [7:0] BYTE_PNG0    = 8'h89;
    localparam logic [7:0] BYTE_SYNC_HI = 8'hE0;

    // Signature tests in priority order: result code and header length needed.
    localparam logic [3:0] SIG_CODE [SIG_COUNT] = '{
        FMT_PNG, FMT_JPEG, FMT_GIF, FMT_BMP, FMT_WEBP, FMT_TIFF, FMT_TIFF,
        FMT_PDF, FMT_WAV, FMT_MP3, FMT_MP3, FMT_MP4, FMT_OGG, FMT_ZIP
    };
    localparam logic [POS_W-1:0] SIG_NEED [SIG_COUNT] = '{
        6'd8, 6'd3, 6'd6, 6'd2, 6'd12, 6'd4, 6'd4,
        6'd5, 6'd12, 6'd3, 6'd2, 6'd8, 6'd4, 6'd4
    };

    typedef struct packed {
        logic [7:0] header_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [3:0]  format_code;
        logic        dims_valid;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic        audio_valid;
        logic [15:0] channel_count;
        logic [31:0] sampling_rate;
        logic [31:0] byte_rate;
    } t_result;

    // One bit per signature test: does byte b at position p agree with it?
    // Positions that a test does not check always agree.
    function automatic logic [SIG_COUNT-1:0] sig_byte_ok(
        input logic [POS_W-1:0] p,
        input logic [7:0]       b
    );
        logic [SIG_COUNT-1:0] ok;
        ok = '1;
        case (p)
            6'd0: begin
                ok[0]  = (b == 8'h89); ok[1]  = (b == 8'hFF); ok[2]  = (b == 8'h47);
                ok[3]  = (b == 8'h42); ok[4]  = (b == 8'h52); ok[5]  = (b == 8'h49);
                ok[6]  = (b == 8'h4D); ok[7]  = (b == 8'h25); ok[8]  = (b == 8'h52);
                ok[9]  = (b == 8'h49); ok[10] = (b == 8'hFF); ok[12] = (b == 8'h4F);
                ok[13] = (b == 8'h50);
            end
            6'd1: begin
                ok[0]  = (b == 8'h50); ok[1]  = (b == 8'hD8); ok[2]  = (b == 8'h49);
                ok[3]  = (b == 8'h4D); ok[4]  = (b == 8'h49); ok[5]  = (b == 8'h49);
                ok[6]  = (b == 8'h4D); ok[7]  = (b == 8'h50); ok[8]  = (b == 8'h49);
                ok[9]  = (b == 8'h44);
                ok[10] = ((b & BYTE_SYNC_HI) == BYTE_SYNC_HI);
                ok[12] = (b == 8'h67); ok[13] = (b == 8'h4B);
            end
            6'd2: begin
                ok[0]  = (b == 8'h4E); ok[1]  = (b == 8'hFF); ok[2]  = (b == 8'h46);
                ok[4]  = (b == 8'h46); ok[5]  = (b == 8'h2A); ok[6]  = (b == 8'h00);
                ok[7]  = (b == 8'h44); ok[8]  = (b == 8'h46); ok[9]  = (b == 8'h33);
                ok[12] = (b == 8'h67); ok[13] = (b == 8'h03);
            end
            6'd3: begin
                ok[0]  = (b == 8'h47); ok[2]  = (b == 8'h38); ok[4]  = (b == 8'h46);
                ok[5]  = (b == 8'h00); ok[6]  = (b == 8'h2A); ok[7]  = (b == 8'h46);
                ok[8]  = (b == 8'h46); ok[12] = (b == 8'h53); ok[13] = (b == 8'h04);
            end
            6'd4: begin
                // Both GIF87a and GIF89a are accepted here.
                ok[0]  = (b == 8'h0D);
                ok[2]  = (b == 8'h37) || (b == 8'h39);
                ok[7]  = (b == 8'h2D);
                ok[11] = (b == 8'h66);
            end
            6'd5: begin
                ok[0] = (b == 8'h0A); ok[2] = (b == 8'h61); ok[11] = (b == 8'h74);
            end
            6'd6: begin
                ok[0] = (b == 8'h1A); ok[11] = (b == 8'h79);
            end
            6'd7: begin
                ok[0] = (b == 8'h0A); ok[11] = (b == 8'h70);
            end
            6'd8: begin
                ok[4] = (b == 8'h57); ok[8] = (b == 8'h57);
            end
            6'd9: begin
                ok[4] = (b == 8'h45); ok[8] = (b == 8'h41);
            end
            6'd10: begin
                ok[4] = (b == 8'h42); ok[8] = (b == 8'h56);
            end
            6'd11: begin
                ok[4] = (b == 8'h50); ok[8] = (b == 8'h45);
            end
            default: ok = '1;
        endcase
        return ok;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/fss_in_stage.sv =====
// Input register of the file signature sniffer: holds one header byte transaction.
// Depends on fss_pkg for the item type.
`default_nettype none
module fss_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire fss_pkg::t_item i_item,
    input  wire logic          i_take,
    output logic               o_valid,
    output fss_pkg::t_item     o_item
);
    import fss_pkg::*;

    logic  r_valid;
    t_item r_item;

    // The register can load whenever it is empty or drains in this cycle.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/fss_track.sv =====
// Per-header tracking state: position count, signature flags and field captures,
// plus the classification of the header on its last byte. Depends on fss_pkg.
`default_nettype none
module fss_track (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_take,
    input  wire fss_pkg::t_item i_item,
    output fss_pkg::t_result    o_result
);
    import fss_pkg::*;

    logic [POS_W-1:0]     r_pos,   n_pos;
    logic [SIG_COUNT-1:0] r_alive, n_alive;
    logic                 r_big,   n_big;
    logic [31:0]          r_width, n_width;
    logic [31:0]          r_height, n_height;
    logic [15:0]          r_chan,  n_chan;
    logic [31:0]          r_rate,  n_rate;
    logic [31:0]          r_brate, n_brate;

    logic [SIG_COUNT-1:0] w_ok;
    logic [7:0]           w_b;
    logic [POS_W-1:0]     w_off18, w_off22, w_off24, w_off28;
    logic [3:0]           w_code;
    logic                 w_found;
    logic                 w_dims;
    logic                 w_audio;

    assign w_b     = i_item.header_byte;
    assign w_ok    = sig_byte_ok(r_pos, w_b);
    assign w_off18 = r_pos - POS_W'(18);
    assign w_off22 = r_pos - POS_W'(22);
    assign w_off24 = r_pos - POS_W'(24);
    assign w_off28 = r_pos - POS_W'(28);

    always_comb begin
        n_pos    = r_pos;
        n_alive  = r_alive;
        n_big    = r_big;
        n_width  = r_width;
        n_height = r_height;
        n_chan   = r_chan;
        n_rate   = r_rate;
        n_brate  = r_brate;
        if (r_pos < POS_SAT) begin
            n_alive = r_alive & w_ok;
            n_pos   = r_pos + POS_W'(1);
            if (r_pos == '0) begin
                n_big = (w_b == BYTE_PNG0);
            end
            // PNG stores dimensions big endian, BMP little endian at other offsets.
            if (r_big) begin
                if (r_pos >= 6'd16 && r_pos < 6'd20) n_width  = {r_width[23:0], w_b};
                if (r_pos >= 6'd20 && r_pos < 6'd24) n_height = {r_height[23:0], w_b};
            end else begin
                if (r_pos >= 6'd18 && r_pos < 6'd22) begin
                    n_width[{w_off18[1:0], 3'b000} +: 8] =
                        r_width[{w_off18[1:0], 3'b000} +: 8] | w_b;
                end
                if (r_pos >= 6'd22 && r_pos < 6'd26) begin
                    n_height[{w_off22[1:0], 3'b000} +: 8] =
                        r_height[{w_off22[1:0], 3'b000} +: 8] | w_b;
                end
            end
            if (r_pos >= 6'd22 && r_pos < 6'd24) begin
                n_chan[{w_off22[0], 3'b000} +: 8] = r_chan[{w_off22[0], 3'b000} +: 8] | w_b;
            end
            if (r_pos >= 6'd24 && r_pos < 6'd28) begin
                n_rate[{w_off24[1:0], 3'b000} +: 8] =
                    r_rate[{w_off24[1:0], 3'b000} +: 8] | w_b;
            end
            if (r_pos >= 6'd28 && r_pos < 6'd32) begin
                n_brate[{w_off28[1:0], 3'b000} +: 8] =
                    r_brate[{w_off28[1:0], 3'b000} +: 8] | w_b;
            end
        end
    end

    // First surviving signature whose bytes all arrived wins.
    always_comb begin
        w_code  = FMT_NONE;
        w_found = 1'b0;
        for (int i = 0; i < SIG_COUNT; i++) begin
            if (!w_found && n_alive[i] && (n_pos >= SIG_NEED[i])) begin
                w_code  = SIG_CODE[i];
                w_found = 1'b1;
            end
        end
    end

    assign w_dims  = ((w_code == FMT_PNG) && (n_pos >= 6'd24)) ||
                     ((w_code == FMT_BMP) && (n_pos >= 6'd26));
    assign w_audio = (w_code == FMT_WAV) && (n_pos >= 6'd36);

    always_comb begin
        o_result.format_code   = w_code;
        o_result.dims_valid    = w_dims;
        o_result.image_width   = w_dims  ? n_width  : '0;
        o_result.image_height  = w_dims  ? n_height : '0;
        o_result.audio_valid   = w_audio;
        o_result.channel_count = w_audio ? n_chan   : '0;
        o_result.sampling_rate = w_audio ? n_rate   : '0;
        o_result.byte_rate     = w_audio ? n_brate  : '0;
    end

    // The last byte of a header returns all tracking state to its start values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_item.last_byte)) begin
            r_pos    <= '0;
            r_alive  <= '1;
            r_big    <= 1'b0;
            r_width  <= '0;
            r_height <= '0;
            r_chan   <= '0;
            r_rate   <= '0;
            r_brate  <= '0;
        end else if (i_take) begin
            r_pos    <= n_pos;
            r_alive  <= n_alive;
            r_big    <= n_big;
            r_width  <= n_width;
            r_height <= n_height;
            r_chan   <= n_chan;
            r_rate   <= n_rate;
            r_brate  <= n_brate;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/file_signature_sniffer.sv =====
// Top level of the file signature sniffer: input stage, tracker and result register.
// Depends on fss_pkg, fss_in_stage and fss_track.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_header_byte, i_last_byte
//  result    out        o_valid / i_ready    o_format_code ... o_byte_rate
//
// One header byte is accepted per cycle unless a waiting last byte stalls the input register;
// each byte sits in the input register, where the tracker consumes it. A byte marked last
// loads its result into the result register at the edge that drains it from the input register.
// Only a last byte waits when the result register still holds an untaken result;
// other bytes keep flowing. Synchronous reset clears the handshake and tracking state.
`default_nettype none
module file_signature_sniffer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_header_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_format_code,
    output logic             o_dims_valid,
    output logic [31:0]      o_image_width,
    output logic [31:0]      o_image_height,
    output logic             o_audio_valid,
    output logic [15:0]      o_channel_count,
    output logic [31:0]      o_sampling_rate,
    output logic [31:0]      o_byte_rate
);
    import fss_pkg::*;

    t_item   w_in_item;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_take;
    t_result w_result;
    logic    r_out_valid;
    t_result r_out;

    assign w_in_item.header_byte = i_header_byte;
    assign w_in_item.last_byte   = i_last_byte;

    assign w_take = w_item_valid && (!w_item.last_byte || !r_out_valid || i_ready);

    fss_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (w_in_item),
        .i_take  (w_take),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    fss_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_item   (w_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take && w_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_item.last_byte) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_format_code   = r_out.format_code;
    assign o_dims_valid    = r_out.dims_valid;
    assign o_image_width   = r_out.image_width;
    assign o_image_height  = r_out.image_height;
    assign o_audio_valid   = r_out.audio_valid;
    assign o_channel_count = r_out.channel_count;
    assign o_sampling_rate = r_out.sampling_rate;
    assign o_byte_rate     = r_out.byte_rate;

endmodule
`default_nettype wire

// ===== rtl/fss_checker.sv =====
// Port-level checks for the file signature sniffer, bound to its top level.
// Depends on fss_pkg for the format codes.
`default_nettype none
module fss_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [3:0]  o_format_code,
    input wire logic        o_dims_valid,
    input wire logic [31:0] o_image_width,
    input wire logic [31:0] o_image_height,
    input wire logic        o_audio_valid,
    input wire logic [15:0] o_channel_count,
    input wire logic [31:0] o_sampling_rate,
    input wire logic [31:0] o_byte_rate
);
    import fss_pkg::*;

    // Dimensions are only reported for PNG or BMP headers.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dims_valid |-> (o_format_code == FMT_PNG) || (o_format_code == FMT_BMP))
        else $error("dimensions flagged for a format without them");

    // Audio fields are only reported for WAV headers.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_audio_valid |-> o_format_code == FMT_WAV)
        else $error("audio fields flagged for a non-WAV format");

    // Fields without meaning read as zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_dims_valid |-> (o_image_width == '0) && (o_image_height == '0))
        else $error("image dimensions nonzero while not valid");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_audio_valid |->
            (o_channel_count == '0) && (o_sampling_rate == '0) && (o_byte_rate == '0))
        else $error("audio fields nonzero while not valid");

    // A stalled result transaction holds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_format_code) && $stable(o_image_width))
        else $error("result changed while stalled");

endmodule

bind file_signature_sniffer fss_checker u_fss_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_format_code   (o_format_code),
    .o_dims_valid    (o_dims_valid),
    .o_image_width   (o_image_width),
    .o_image_height  (o_image_height),
    .o_audio_valid   (o_audio_valid),
    .o_channel_count (o_channel_count),
    .o_sampling_rate (o_sampling_rate),
    .o_byte_rate     (o_byte_rate)
);
`default_nettype wire

// ===== tb/sv/tb_file_signature_sniffer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for file_signature_sniffer: streams file headers byte by byte
// and checks each detected format and captured field against a local prediction.
// Depends on fss_pkg and the file_signature_sniffer RTL.

// Signature shapes shared by the scoreboard and the header generator.
package tb_sig_pkg;
    localparam int SIG_TOTAL  = 14;
    localparam int SIG_GIF    = 2;
    localparam int SIG_SYNC   = 10;
    localparam int POS_LIMIT  = 37;

    // Pattern of a signature test: the bytes it checks within the first twelve,
    // and how many header bytes must have arrived before it can match.
    function automatic void sig_shape(input int s, output logic [0:11][7:0] pat,
                                      output logic [0:11] chk, output int unsigned need);
        case (s)
            0:  begin pat = 96'h89504E47_0D0A1A0A_00000000; chk = 12'hFF0; end
            1:  begin pat = 96'hFFD8FF00_00000000_00000000; chk = 12'hE00; end
            2:  begin pat = 96'h47494638_37610000_00000000; chk = 12'hFC0; end
            3:  begin pat = 96'h424D0000_00000000_00000000; chk = 12'hC00; end
            4:  begin pat = 96'h52494646_00000000_57454250; chk = 12'hF0F; end
            5:  begin pat = 96'h49492A00_00000000_00000000; chk = 12'hF00; end
            6:  begin pat = 96'h4D4D002A_00000000_00000000; chk = 12'hF00; end
            7:  begin pat = 96'h25504446_2D000000_00000000; chk = 12'hF80; end
            8:  begin pat = 96'h52494646_00000000_57415645; chk = 12'hF0F; end
            9:  begin pat = 96'h49443300_00000000_00000000; chk = 12'hE00; end
            10: begin pat = 96'hFFE00000_00000000_00000000; chk = 12'hC00; end
            11: begin pat = 96'h00000000_66747970_00000000; chk = 12'h0F0; end
            12: begin pat = 96'h4F676753_00000000_00000000; chk = 12'hF00; end
            default: begin pat = 96'h504B0304_00000000_00000000; chk = 12'hF00; end
        endcase
        need = 0;
        for (int k = 0; k < 12; k++)
            if (chk[k]) need = k + 1;
    endfunction
endpackage

// Tracks the header in flight the way the block does and keeps the verdicts still owed.
class signature_scoreboard;
    fss_pkg::t_result expected_verdicts[$];
    int unsigned byte_count;
    logic [tb_sig_pkg::SIG_TOTAL-1:0] still_alive;
    logic [7:0]  lead_byte;
    logic [31:0] width_word;
    logic [31:0] height_word;
    logic [15:0] channel_word;
    logic [31:0] rate_word;
    logic [31:0] byterate_word;
    int unsigned errors;
    int unsigned verdicts_checked;
    int unsigned headers_seen;
    int unsigned bytes_seen;
    int unsigned format_seen[16];

    function new();
        errors = 0;
        verdicts_checked = 0;
        headers_seen = 0;
        bytes_seen = 0;
        foreach (format_seen[f]) format_seen[f] = 0;
        clear_header();
    endfunction

    function void clear_header();
        byte_count    = 0;
        still_alive   = '1;
        lead_byte     = 8'h00;
        width_word    = '0;
        height_word   = '0;
        channel_word  = '0;
        rate_word     = '0;
        byterate_word = '0;
    endfunction

    static function logic [3:0] sig_format(int s);
        case (s)
            0:       return fss_pkg::FMT_PNG;
            1:       return fss_pkg::FMT_JPEG;
            2:       return fss_pkg::FMT_GIF;
            3:       return fss_pkg::FMT_BMP;
            4:       return fss_pkg::FMT_WEBP;
            5, 6:    return fss_pkg::FMT_TIFF;
            7:       return fss_pkg::FMT_PDF;
            8:       return fss_pkg::FMT_WAV;
            9, 10:   return fss_pkg::FMT_MP3;
            11:      return fss_pkg::FMT_MP4;
            12:      return fss_pkg::FMT_OGG;
            default: return fss_pkg::FMT_ZIP;
        endcase
    endfunction

    function bit byte_agrees(int s, int unsigned p, logic [7:0] b);
        logic [0:11][7:0] pat;
        logic [0:11] chk;
        int unsigned need;
        tb_sig_pkg::sig_shape(s, pat, chk, need);
        if (p >= 12 || !chk[p]) return 1'b1;
        // GIF89a is accepted as well as GIF87a.
        if (s == tb_sig_pkg::SIG_GIF && p == 4 && b == 8'h39) return 1'b1;
        // An MP3 frame sync only needs the top three bits of its second byte.
        if (s == tb_sig_pkg::SIG_SYNC && p == 1) return (b & 8'hE0) == 8'hE0;
        return b == pat[p];
    endfunction

    function void note_byte(logic [7:0] b, logic is_last);
        logic big_endian;
        fss_pkg::t_result v;
        logic [0:11][7:0] pat;
        logic [0:11] chk;
        int unsigned need;
        bytes_seen++;
        big_endian = (lead_byte == 8'h89);
        if (byte_count < tb_sig_pkg::POS_LIMIT) begin
            for (int s = 0; s < tb_sig_pkg::SIG_TOTAL; s++)
                if (!byte_agrees(s, byte_count, b)) still_alive[s] = 1'b0;
            if (byte_count == 0) lead_byte = b;
            if (big_endian) begin
                if (byte_count >= 16 && byte_count < 20) width_word = {width_word[23:0], b};
                if (byte_count >= 20 && byte_count < 24) height_word = {height_word[23:0], b};
            end else begin
                if (byte_count >= 18 && byte_count < 22)
                    width_word[8*(byte_count-18) +: 8] = b;
                if (byte_count >= 22 && byte_count < 26)
                    height_word[8*(byte_count-22) +: 8] = b;
            end
            if (byte_count >= 22 && byte_count < 24) channel_word[8*(byte_count-22) +: 8] = b;
            if (byte_count >= 24 && byte_count < 28) rate_word[8*(byte_count-24) +: 8] = b;
            if (byte_count >= 28 && byte_count < 32) byterate_word[8*(byte_count-28) +: 8] = b;
            byte_count++;
        end
        if (!is_last) return;

        v = '0;
        v.format_code = fss_pkg::FMT_NONE;
        for (int s = 0; s < tb_sig_pkg::SIG_TOTAL; s++) begin
            tb_sig_pkg::sig_shape(s, pat, chk, need);
            if (still_alive[s] && byte_count >= need) begin
                v.format_code = sig_format(s);
                break;
            end
        end
        v.dims_valid = (v.format_code == fss_pkg::FMT_PNG && byte_count >= 24) ||
                       (v.format_code == fss_pkg::FMT_BMP && byte_count >= 26);
        v.audio_valid = (v.format_code == fss_pkg::FMT_WAV && byte_count >= 36);
        if (v.dims_valid) begin
            v.image_width  = width_word;
            v.image_height = height_word;
        end
        if (v.audio_valid) begin
            v.channel_count = channel_word;
            v.sampling_rate = rate_word;
            v.byte_rate     = byterate_word;
        end
        expected_verdicts.push_back(v);
        format_seen[v.format_code]++;
        headers_seen++;
        clear_header();
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    function void check_verdict(fss_pkg::t_result got);
        fss_pkg::t_result want;
        if (expected_verdicts.size() == 0) begin
            errors++;
            $display("%0t: result with no header pending, expected none, actual code %0d",
                     $time, got.format_code);
            return;
        end
        want = expected_verdicts.pop_front();
        verdicts_checked++;
        compare_field("format_code",   want.format_code,   got.format_code);
        compare_field("dims_valid",    want.dims_valid,    got.dims_valid);
        compare_field("image_width",   want.image_width,   got.image_width);
        compare_field("image_height",  want.image_height,  got.image_height);
        compare_field("audio_valid",   want.audio_valid,   got.audio_valid);
        compare_field("channel_count", want.channel_count, got.channel_count);
        compare_field("sampling_rate", want.sampling_rate, got.sampling_rate);
        compare_field("byte_rate",     want.byte_rate,     got.byte_rate);
    endfunction

    function int unsigned pending();
        return expected_verdicts.size();
    endfunction

    function void report_leftover();
        if (expected_verdicts.size() != 0) begin
            errors++;
            $display("%0t: %0d results expected, actual none arrived", $time,
                     expected_verdicts.size());
        end
    endfunction
endclass

module tb_file_signature_sniffer;
    import tb_sig_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int ITEM_TARGET = 1100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_header_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_format_code;
    logic        o_dims_valid;
    logic [31:0] o_image_width;
    logic [31:0] o_image_height;
    logic        o_audio_valid;
    logic [15:0] o_channel_count;
    logic [31:0] o_sampling_rate;
    logic [31:0] o_byte_rate;

    signature_scoreboard sb;
    logic [7:0]  hdr_bytes[$];
    int unsigned feed_gap_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    file_signature_sniffer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_header_byte  (i_header_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_format_code  (o_format_code),
        .o_dims_valid   (o_dims_valid),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_audio_valid  (o_audio_valid),
        .o_channel_count(o_channel_count),
        .o_sampling_rate(o_sampling_rate),
        .o_byte_rate    (o_byte_rate)
    );

    // Result side: take and check results, stall at random, and watch for a hang.
    always @(posedge i_clk) begin
        fss_pkg::t_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.format_code   = o_format_code;
            got.dims_valid    = o_dims_valid;
            got.image_width   = o_image_width;
            got.image_height  = o_image_height;
            got.audio_valid   = o_audio_valid;
            got.channel_count = o_channel_count;
            got.sampling_rate = o_sampling_rate;
            got.byte_rate     = o_byte_rate;
            sb.check_verdict(got);
        end
        i_ready <= ($urandom_range(99) >= sink_stall_pct);
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("tb_file_signature_sniffer failed");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the byte was taken.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if ($urandom_range(99) < feed_gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < feed_gap_pct);
        end
        i_valid       <= 1'b1;
        i_header_byte <= b;
        i_last_byte   <= is_last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_byte(b, is_last);
    endtask

    task automatic send_header();
        for (int k = 0; k < hdr_bytes.size(); k++)
            send_byte(hdr_bytes[k], k == hdr_bytes.size() - 1);
    endtask

    // A header that mostly carries a known signature with random content around it;
    // some are pure noise, some have a corrupted byte, and lengths vary widely.
    task automatic random_header();
        logic [0:11][7:0] pat;
        logic [0:11] chk;
        int unsigned need;
        int unsigned kind;
        int unsigned len;
        int unsigned r;
        int unsigned k;
        kind = $urandom_range(SIG_TOTAL);
        r = $urandom_range(99);
        if (r < 3)       len = $urandom_range(80, 60);
        else if (r < 30) len = $urandom_range(12, 1);
        else if (r < 70) len = $urandom_range(27, 12);
        else             len = $urandom_range(44, 28);
        hdr_bytes.delete();
        repeat (len) hdr_bytes.push_back(8'($urandom));
        if (kind < SIG_TOTAL) begin
            sig_shape(kind, pat, chk, need);
            for (k = 0; k < 12 && k < len; k++)
                if (chk[k]) hdr_bytes[k] = pat[k];
            if (kind == SIG_GIF && len > 4 && $urandom_range(1))
                hdr_bytes[4] = 8'h39;
            if (kind == SIG_SYNC && len > 1)
                hdr_bytes[1] = 8'hE0 | 8'($urandom);
        end
        if ($urandom_range(99) < 15) begin
            k = $urandom_range(len > 12 ? 11 : len - 1);
            hdr_bytes[k] = hdr_bytes[k] ^ 8'($urandom_range(255, 1));
        end
        send_header();
    endtask

    initial begin
        string tally;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin feed_gap_pct = 7;  sink_stall_pct = 59; end
                1:       begin feed_gap_pct = 59; sink_stall_pct = 7;  end
                default: begin feed_gap_pct = 0;  sink_stall_pct = 0;  end
            endcase
            if (phase == 0) begin
                // Short headers: extreme byte values, the shortest matches, jpeg told apart from
                // an mp3 frame sync, and a png lead cut off too early to match.
                hdr_bytes = '{8'h00};                    send_header();
                hdr_bytes = '{8'hFF};                    send_header();
                hdr_bytes = '{8'h42, 8'h4D};             send_header();
                hdr_bytes = '{8'hFF, 8'hD8, 8'hFF};      send_header();
                hdr_bytes = '{8'hFF, 8'hFF};             send_header();
                hdr_bytes = '{8'h49, 8'h44, 8'h33};      send_header();
                hdr_bytes = '{8'h89, 8'h50, 8'h4E};      send_header();
                hdr_bytes = '{8'h50, 8'h4B, 8'h03, 8'h04}; send_header();
                hdr_bytes = '{8'h80, 8'h7F};             send_header();
            end
            while (sb.bytes_seen < (phase + 1) * ITEM_TARGET / 3 ||
                   (phase == 2 && sb.headers_seen < 60))
                random_header();
            // Hold the input side until every owed result has been taken.
            i_valid <= 1'b0;
            do @(posedge i_clk); while (sb.pending() != 0);
        end

        repeat (8) @(posedge i_clk);
        sb.report_leftover();

        tally = "";
        for (int f = 0; f < 13; f++) tally = {tally, $sformatf(" %0d", sb.format_seen[f])};
        $display("Streamed %0d headers (%0d bytes) under three handshake mixes,",
                 sb.headers_seen, sb.bytes_seen);
        $display("%0d results checked; results per format code 0..12:%s",
                 sb.verdicts_checked, tally);
        if (sb.errors == 0)
            $display("tb_file_signature_sniffer passed");
        else
            $display("tb_file_signature_sniffer failed");
        $finish;
    end
endmodule

// ===== file_signature_sniffer.f =====
rtl/fss_pkg.sv
rtl/fss_in_stage.sv
rtl/fss_track.sv
rtl/file_signature_sniffer.sv
rtl/fss_checker.sv
tb/sv/tb_file_signature_sniffer.sv
